// ===== rtl/core/tccs_pkg.sv =====
`default_nettype none

package tccs_pkg;

  // screen geometry defaults
  localparam int COLS_DEFAULT = 80;
  localparam int ROWS_DEFAULT = 25;

  // character codes
  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] BS_CHAR    = 8'h08;
  localparam logic [7:0] LF_CHAR    = 8'h0A;
  localparam logic [7:0] CR_CHAR    = 8'h0D;

  // attribute every cell holds after reset
  localparam logic [7:0] RESET_ATTR = 8'h07;

  typedef enum logic [1:0] {
    CMD_PRINT      = 2'd0,
    CMD_SET_CURSOR = 2'd1,
    CMD_CLEAR      = 2'd2,
    CMD_READ       = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/text_console_cursor_scroll_core.sv =====
`default_nettype none

// Text console engine: a COLS x ROWS store of character cells and a cursor.
// Request channel: item_valid / item_stall carry cmd, char_byte, col, row.
// A request is taken when item_valid is high and item_stall is low; the
// block raises item_stall while it works on a request.
// Result channel: result_valid / result_stall carry cursor_pos, read_char
// and read_attr, one result per request, held in an output register that
// stays put while the receiver stalls.
// Configuration: cfg_valid / cfg_ready write the fill attribute from cfg_data;
// cfg_ready is always high.
// A print or set cursor request goes through the execute step to the output
// step; a cell read adds a memory read step; clear screen blanks every cell,
// one cell written a cycle; a print that scrolls runs a copy pass that moves
// every row up a row, then the bottom row fill. The block returns to idle as
// it loads the result and takes the next request from there. A result waiting
// on a stalled receiver holds the next request in its last step until that
// result is taken. Reset (rst, synchronous) homes the cursor, loads fill
// attribute 0x07 and runs a clearing pass over every cell with item_stall
// high; cfg writes go on.

module text_console_cursor_scroll_core #(
  parameter int COLS = tccs_pkg::COLS_DEFAULT,
  parameter int ROWS = tccs_pkg::ROWS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  char_byte,
  input  logic [6:0]  col,
  input  logic [4:0]  row,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [10:0] cursor_pos,
  output logic [7:0]  read_char,
  output logic [7:0]  read_attr,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] SHIFT_END = AW'(CELLS - COLS);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);

  tccs_pkg::state_t state, state_next;

  // sweep counter, shared by the clearing pass, the scroll copy and fills
  logic [AW-1:0] cnt, cnt_next;

  logic [CW-1:0] cursor_col, cursor_col_next;
  logic [RW-1:0] cursor_row, cursor_row_next;

  // latched request
  tccs_pkg::cmd_t req_cmd;
  logic [7:0]     req_char;
  logic [6:0]     req_col;
  logic [4:0]     req_row;

  // read address held for a cell read
  logic [AW-1:0] addr_q, addr_next;

  logic [7:0] fill_attr;

  // cell memory: character and attribute bytes, one write and one read port
  logic [7:0] char_mem [CELLS];
  logic [7:0] attr_mem [CELLS];
  logic [7:0] rd_char_q, rd_attr_q;

  logic          wr_en, wr_char_en, wr_attr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_char, wr_attr;

  logic load_result;

  logic [31:0]   pos32;
  logic [AW-1:0] cur_addr;
  logic [CW-1:0] col_clamp;
  logic [RW-1:0] row_clamp;
  logic [AW-1:0] clamp_addr;

  logic accept;

  assign item_stall = (state != tccs_pkg::ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;

  // linear cursor position, also the cell address under the cursor
  assign pos32    = 32'(cursor_row) * 32'(COLS) + 32'(cursor_col);
  assign cur_addr = AW'(pos32);

  // coordinates saturate at the screen edge
  assign col_clamp  = (req_col > 7'(COLS - 1)) ? COL_LAST : CW'(req_col);
  assign row_clamp  = (32'(req_row) > 32'(ROWS - 1)) ? ROW_LAST : RW'(req_row);
  assign clamp_addr = AW'(32'(row_clamp) * 32'(COLS) + 32'(col_clamp));

  // fill attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_attr <= tccs_pkg::RESET_ATTR;
    end else if (cfg_valid && cfg_ready) begin
      fill_attr <= cfg_data;
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd  <= tccs_pkg::cmd_t'(cmd);
      req_char <= char_byte;
      req_col  <= col;
      req_row  <= row;
    end
  end

  // cell memory
  always_ff @(posedge clk) begin
    if (wr_en && wr_char_en) begin
      char_mem[wr_addr] <= wr_char;
    end
    if (wr_en && wr_attr_en) begin
      attr_mem[wr_addr] <= wr_attr;
    end
    rd_char_q <= char_mem[rd_addr];
    rd_attr_q <= attr_mem[rd_addr];
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tccs_pkg::ST_INIT;
      cnt        <= '0;
      cursor_col <= '0;
      cursor_row <= '0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
    end
  end

  always_ff @(posedge clk) begin
    addr_q <= addr_next;
  end

  // next state, memory port control
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    addr_next       = addr_q;
    wr_en           = 1'b0;
    wr_char_en      = 1'b0;
    wr_attr_en      = 1'b0;
    wr_addr         = cnt;
    wr_char         = tccs_pkg::BLANK_CHAR;
    wr_attr         = fill_attr;
    rd_addr         = addr_q;
    load_result     = 1'b0;

    case (state)
      tccs_pkg::ST_INIT: begin
        // power-up clearing pass with the reset attribute
        wr_en      = 1'b1;
        wr_char_en = 1'b1;
        wr_attr_en = 1'b1;
        wr_attr    = tccs_pkg::RESET_ATTR;
        if (cnt == LAST_CELL) begin
          cnt_next   = '0;
          state_next = tccs_pkg::ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      tccs_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = tccs_pkg::ST_EXEC;
        end
      end

      tccs_pkg::ST_EXEC: begin
        state_next = tccs_pkg::ST_OUT;
        case (req_cmd)
          tccs_pkg::CMD_PRINT: begin
            case (req_char)
              tccs_pkg::BS_CHAR: begin
                if (cursor_col != '0) begin
                  cursor_col_next = cursor_col - 1'b1;
                end
              end
              tccs_pkg::LF_CHAR: begin
                cursor_col_next = '0;
                if (cursor_row == ROW_LAST) begin
                  cnt_next   = '0;
                  state_next = tccs_pkg::ST_SCROLL;
                end else begin
                  cursor_row_next = cursor_row + 1'b1;
                end
              end
              tccs_pkg::CR_CHAR: begin
                cursor_col_next = '0;
              end
              default: begin
                // printable: replace the character byte, keep the attribute
                wr_en      = 1'b1;
                wr_char_en = 1'b1;
                wr_addr    = cur_addr;
                wr_char    = req_char;
                if (cursor_col == COL_LAST) begin
                  cursor_col_next = '0;
                  if (cursor_row == ROW_LAST) begin
                    cnt_next   = '0;
                    state_next = tccs_pkg::ST_SCROLL;
                  end else begin
                    cursor_row_next = cursor_row + 1'b1;
                  end
                end else begin
                  cursor_col_next = cursor_col + 1'b1;
                end
              end
            endcase
          end
          tccs_pkg::CMD_SET_CURSOR: begin
            cursor_col_next = col_clamp;
            cursor_row_next = row_clamp;
          end
          tccs_pkg::CMD_CLEAR: begin
            cursor_col_next = '0;
            cursor_row_next = '0;
            cnt_next        = '0;
            state_next      = tccs_pkg::ST_FILL;
          end
          tccs_pkg::CMD_READ: begin
            addr_next  = clamp_addr;
            state_next = tccs_pkg::ST_READ;
          end
          default: begin
            state_next = tccs_pkg::ST_OUT;
          end
        endcase
      end

      tccs_pkg::ST_READ: begin
        // read data lands in rd_*_q and stays while addr_q holds
        state_next = tccs_pkg::ST_OUT;
      end

      tccs_pkg::ST_SCROLL: begin
        // read the cell one row down, write it back one row up in the next cycle
        if (cnt != SHIFT_END) begin
          rd_addr = AW'(32'(cnt) + 32'(COLS));
        end
        if (cnt != '0) begin
          wr_en      = 1'b1;
          wr_char_en = 1'b1;
          wr_attr_en = 1'b1;
          wr_addr    = cnt - 1'b1;
          wr_char    = rd_char_q;
          wr_attr    = rd_attr_q;
        end
        if (cnt == SHIFT_END) begin
          state_next = tccs_pkg::ST_FILL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      tccs_pkg::ST_FILL: begin
        // blanks in the fill attribute from cnt to the last cell
        wr_en      = 1'b1;
        wr_char_en = 1'b1;
        wr_attr_en = 1'b1;
        if (cnt == LAST_CELL) begin
          cnt_next   = '0;
          state_next = tccs_pkg::ST_OUT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      tccs_pkg::ST_OUT: begin
        if (!result_valid || !result_stall) begin
          load_result = 1'b1;
          state_next  = tccs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = tccs_pkg::ST_IDLE;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      cursor_pos <= pos32[10:0];
      read_char  <= (req_cmd == tccs_pkg::CMD_READ) ? rd_char_q : 8'h00;
      read_attr  <= (req_cmd == tccs_pkg::CMD_READ) ? rd_attr_q : 8'h00;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tccs_checker.sv =====
`default_nettype none

module tccs_checker #(
  parameter int COLS = tccs_pkg::COLS_DEFAULT,
  parameter int ROWS = tccs_pkg::ROWS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [10:0] cursor_pos,
  input logic [7:0]  read_char,
  input logic [7:0]  read_attr
);

  localparam int CELLS = COLS * ROWS;

  // reset starts the clearing pass, no request is taken right after
  a_reset_blocks: assert property (@(posedge clk) rst |=> item_stall)
    else $error("request path open right after reset");

  // one request at a time: a taken request closes the input
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("second request taken while one is at work");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(cursor_pos)
      && $stable(read_char) && $stable(read_attr)))
    else $error("stalled result changed");

  // the cursor stays on the screen
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((CELLS > 2048) || (32'(cursor_pos) < 32'(CELLS))))
    else $error("cursor position off the screen");

endmodule

bind text_console_cursor_scroll_core tccs_checker #(
  .COLS(COLS),
  .ROWS(ROWS)
) u_tccs_checker (.*);

`default_nettype wire

// ===== bench/console_screen_checker.sv =====
`timescale 1ns / 1ps

module console_screen_checker
  import tccs_pkg::*;
#(
  parameter int COLS = COLS_DEFAULT,
  parameter int ROWS = ROWS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  char_byte,
  input  logic [6:0]  col,
  input  logic [4:0]  row,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [10:0] cursor_pos,
  input  logic [7:0]  read_char,
  input  logic [7:0]  read_attr,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          error_count,
  output int          outstanding
);

  localparam int CELLS = COLS * ROWS;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
  } cursor_report_t;

  // mirror of the screen: attribute in 15..8, character in 7..0
  logic [15:0]    screen [CELLS];
  int             cur_col;
  int             cur_row;
  logic [7:0]     fill_attr;
  cursor_report_t awaited_reports [$];
  cursor_report_t oldest;
  int             reports_seen;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  task automatic apply_console_request(input cmd_t op, input logic [7:0] ch,
                                       input logic [6:0] c_in, input logic [4:0] r_in);
    int             c;
    int             r;
    int             i;
    cursor_report_t res;
    c = (int'(c_in) > COLS - 1) ? COLS - 1 : int'(c_in);
    r = (int'(r_in) > ROWS - 1) ? ROWS - 1 : int'(r_in);
    res = '0;
    case (op)
      CMD_PRINT: begin
        if (ch == BS_CHAR) begin
          if (cur_col > 0) cur_col--;
        end else if (ch == LF_CHAR) begin
          cur_col = 0;
          cur_row++;
        end else if (ch == CR_CHAR) begin
          cur_col = 0;
        end else begin
          // only the character byte changes, attribute stays
          screen[cur_row * COLS + cur_col][7:0] = ch;
          cur_col++;
          if (cur_col >= COLS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        if (cur_row >= ROWS) begin
          for (i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
          for (i = CELLS - COLS; i < CELLS; i++) screen[i] = {fill_attr, BLANK_CHAR};
          cur_row = ROWS - 1;
        end
      end
      CMD_SET_CURSOR: begin
        cur_col = c;
        cur_row = r;
      end
      CMD_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen[i] = {fill_attr, BLANK_CHAR};
        cur_col = 0;
        cur_row = 0;
      end
      default: begin
        res.read_char = screen[r * COLS + c][7:0];
        res.read_attr = screen[r * COLS + c][15:8];
      end
    endcase
    res.cursor_pos = 11'(cur_row * COLS + cur_col);
    awaited_reports.push_back(res);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CELLS; k++) screen[k] = {RESET_ATTR, BLANK_CHAR};
      cur_col = 0;
      cur_row = 0;
      fill_attr = RESET_ATTR;
      awaited_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) fill_attr = cfg_data;
      if (result_valid && !result_stall) begin
        reports_seen++;
        if (awaited_reports.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none awaited (pos %0d)",
                                    reports_seen, cursor_pos));
        end else begin
          oldest = awaited_reports.pop_front();
          if (cursor_pos !== oldest.cursor_pos)
            report_mismatch($sformatf("result %0d cursor_pos got %0d expected %0d",
                                      reports_seen, cursor_pos, oldest.cursor_pos));
          if (read_char !== oldest.read_char)
            report_mismatch($sformatf("result %0d read_char got %h expected %h",
                                      reports_seen, read_char, oldest.read_char));
          if (read_attr !== oldest.read_attr)
            report_mismatch($sformatf("result %0d read_attr got %h expected %h",
                                      reports_seen, read_attr, oldest.read_attr));
        end
      end
      if (item_valid && !item_stall)
        apply_console_request(cmd_t'(cmd), char_byte, col, row);
    end
    outstanding = awaited_reports.size();
  end

endmodule

// ===== bench/text_console_cursor_scroll_core_tb.sv =====
`timescale 1ns / 1ps

module text_console_cursor_scroll_core_tb;
  import tccs_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  // request channel
  logic        item_valid;
  logic        item_stall;
  logic [1:0]  cmd;
  logic [7:0]  char_byte;
  logic [6:0]  col;
  logic [4:0]  row;
  // result channel
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [10:0] cursor_pos;
  logic [7:0]  read_char;
  logic [7:0]  read_attr;
  // fill attribute write
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  int error_count;
  int outstanding;

  // idle rates in percent, sender side and receiver side
  int gap_pct = 0;
  int stall_pct = 0;

  // long receiver hold-off, run from its own process
  logic hold_off = 1'b0;
  bit   start_hold = 1'b0;

  int requests_sent = 0;

  always #2 clk = ~clk;

  text_console_cursor_scroll_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .cmd          (cmd),
    .char_byte    (char_byte),
    .col          (col),
    .row          (row),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cursor_pos   (cursor_pos),
    .read_char    (read_char),
    .read_attr    (read_attr),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  console_screen_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .cmd          (cmd),
    .char_byte    (char_byte),
    .col          (col),
    .row          (row),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cursor_pos   (cursor_pos),
    .read_char    (read_char),
    .read_attr    (read_attr),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .error_count  (error_count),
    .outstanding  (outstanding)
  );

  // receiver: random stalls, plus the long hold-off when it is on
  always @(posedge clk) begin
    result_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
  end

  // hold the result side for a long stretch so the block backs up
  // and has to stall its request side
  initial begin
    wait (start_hold);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (600) @(posedge clk);
    hold_off <= 1'b0;
  end

  // hard limit: far above the slowest legal run (every request scrolling)
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // offer one request and return at the edge that takes it; valid stays
  // high so back-to-back requests need no extra assignment
  task automatic send_request(input cmd_t op, input logic [7:0] ch,
                              input logic [6:0] cc, input logic [4:0] rr);
    while ($urandom_range(0, 99) < gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    cmd        <= op;
    char_byte  <= ch;
    col        <= cc;
    row        <= rr;
    do @(posedge clk); while (item_stall);
    requests_sent++;
  endtask

  // stop offering and wait at falling edges until every result is back
  task automatic drain_results();
    item_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // the fill attribute only changes while the block has nothing in flight
  task automatic write_fill_attr(input logic [7:0] attr);
    drain_results();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= attr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // random requests, mostly well-formed text runs that get read back
  task automatic run_random_phase(input int count);
    int         target;
    int         kind;
    int         n;
    int         p;
    logic [6:0] c0;
    logic [4:0] r0;
    logic [7:0] ch;
    target = requests_sent + count;
    while (requests_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        // place the cursor, print a short run, read some of it back
        c0 = 7'($urandom_range(0, 79));
        r0 = 5'($urandom_range(0, 24));
        send_request(CMD_SET_CURSOR, 8'($urandom_range(0, 255)), c0, r0);
        n = $urandom_range(1, 12);
        repeat (n) begin
          p = $urandom_range(0, 99);
          if (p < 80) ch = 8'($urandom_range(8'h20, 8'h7e));
          else if (p < 85) ch = BS_CHAR;
          else if (p < 88) ch = LF_CHAR;
          else if (p < 92) ch = CR_CHAR;
          else ch = 8'($urandom_range(0, 255));
          send_request(CMD_PRINT, ch, 7'($urandom_range(0, 127)),
                       5'($urandom_range(0, 31)));
        end
        repeat ($urandom_range(1, 3))
          send_request(CMD_READ, 8'($urandom_range(0, 255)),
                       7'(c0 + $urandom_range(0, 3)), r0);
      end else if (kind < 85) begin
        // lone request with every field at random, out-of-range coordinates too
        case ($urandom_range(0, 2))
          0: send_request(CMD_PRINT, 8'($urandom_range(0, 255)),
                          7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
          1: send_request(CMD_SET_CURSOR, 8'($urandom_range(0, 255)),
                          7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
          default: send_request(CMD_READ, 8'($urandom_range(0, 255)),
                                7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
        endcase
      end else if (kind < 90) begin
        send_request(CMD_CLEAR, 8'($urandom_range(0, 255)),
                     7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
      end else begin
        // run off the bottom row to force scrolls, then look at the moved text
        c0 = 7'($urandom_range(70, 79));
        send_request(CMD_SET_CURSOR, 8'($urandom_range(0, 255)), c0,
                     5'(ROWS_DEFAULT - 1));
        n = $urandom_range(1, 12);
        repeat (n) begin
          ch = ($urandom_range(0, 99) < 15) ? LF_CHAR : 8'($urandom_range(8'h21, 8'h7e));
          send_request(CMD_PRINT, ch, 7'($urandom_range(0, 127)),
                       5'($urandom_range(0, 31)));
        end
        send_request(CMD_READ, 8'($urandom_range(0, 255)), c0, 5'(ROWS_DEFAULT - 2));
        send_request(CMD_READ, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 79)),
                     5'(ROWS_DEFAULT - 1));
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    cmd        = CMD_PRINT;
    char_byte  = 8'h00;
    col        = 7'd0;
    row        = 5'd0;
    cfg_valid  = 1'b0;
    cfg_data   = 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // sender idles lightly, receiver heavily
    gap_pct = 21;
    stall_pct <= 59;

    // reset contents, then a read with both coordinates saturating
    send_request(CMD_READ, 8'h00, 7'd0, 5'd0);
    send_request(CMD_READ, 8'hff, 7'h7f, 5'h1f);
    // printable extremes, then the control characters
    send_request(CMD_PRINT, 8'h41, 7'h7f, 5'h1f);
    send_request(CMD_PRINT, 8'hff, 7'd0, 5'd0);
    send_request(CMD_PRINT, 8'h00, 7'd3, 5'd9);
    send_request(CMD_PRINT, BS_CHAR, 7'd0, 5'd0);
    send_request(CMD_PRINT, CR_CHAR, 7'd0, 5'd0);
    // backspace at column zero must leave everything alone
    send_request(CMD_PRINT, BS_CHAR, 7'd0, 5'd0);
    send_request(CMD_READ, 8'h00, 7'd0, 5'd0);
    // set cursor saturates to the bottom-right cell
    send_request(CMD_SET_CURSOR, 8'h00, 7'h7f, 5'h1f);
    // printing there wraps past the last row and scrolls
    send_request(CMD_PRINT, 8'h5a, 7'd0, 5'd0);

    // new fill attribute: the next scroll blanks the bottom row with it
    write_fill_attr(8'hff);
    send_request(CMD_PRINT, LF_CHAR, 7'd0, 5'd0);
    send_request(CMD_READ, 8'h00, 7'd79, 5'd22);
    send_request(CMD_READ, 8'h00, 7'd0, 5'd24);
    // right edge wrap on the top row, no scroll
    send_request(CMD_SET_CURSOR, 8'h00, 7'd79, 5'd0);
    send_request(CMD_PRINT, 8'h7e, 7'd0, 5'd0);
    send_request(CMD_CLEAR, 8'h00, 7'd0, 5'd0);
    send_request(CMD_READ, 8'h00, 7'd40, 5'd12);

    write_fill_attr(8'h00);
    send_request(CMD_CLEAR, 8'hff, 7'h7f, 5'h1f);
    send_request(CMD_READ, 8'h00, 7'd79, 5'd24);
    // line feed on the top row of the screen
    send_request(CMD_PRINT, LF_CHAR, 7'd0, 5'd0);
    send_request(CMD_PRINT, 8'h80, 7'd0, 5'd0);
    send_request(CMD_READ, 8'h00, 7'd0, 5'd1);

    write_fill_attr(8'($urandom_range(0, 255)));
    run_random_phase(95);

    // the other way round
    write_fill_attr(8'($urandom_range(0, 255)));
    gap_pct = 59;
    stall_pct <= 21;
    run_random_phase(95);

    // no idling at all, with the long hold-off on the result side
    write_fill_attr(8'($urandom_range(0, 255)));
    gap_pct = 0;
    stall_pct <= 0;
    start_hold = 1'b1;
    run_random_phase(95);

    drain_results();
    repeat (100) @(posedge clk);
    if (error_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
